// ===== rtl/core/bxds_pkg.sv =====
// bxds_pkg: types and constants shared by the box average downscaler
// holds the per-channel sum word, pipeline stage words and register indexes
// no dependencies
`default_nettype none

package bxds_pkg;

   // field and counter widths
   localparam int PIX_W     = 8;
   localparam int DIM_W     = 13;
   localparam int POS_W     = 12;
   localparam int FACT_W    = 5;
   localparam int N_W       = 2 * FACT_W;
   localparam int QUO_W     = 8;
   // a block of up to 31 x 31 pixels at 255 fits in 18 bits
   localparam int SUM_W     = 18;
   localparam int CSR_IDX_W = 2;

   localparam logic [DIM_W-1:0]  DIM_MAX         = 13'd4096;
   localparam logic [DIM_W-1:0]  WIDTH_RESET     = 13'd640;
   localparam logic [DIM_W-1:0]  HEIGHT_RESET    = 13'd480;
   localparam logic [FACT_W-1:0] FACTOR_RESET    = 5'd2;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SOURCE_WIDTH  = 2'd0,
      CSR_SOURCE_HEIGHT = 2'd1,
      CSR_SCALE_FACTOR  = 2'd2
   } csr_reg_type;

   typedef struct packed {
      logic [SUM_W-1:0] r;
      logic [SUM_W-1:0] g;
      logic [SUM_W-1:0] b;
   } rgb_sum_type;

   typedef struct packed {
      logic [QUO_W-1:0] r;
      logic [QUO_W-1:0] g;
      logic [QUO_W-1:0] b;
   } rgb_quo_type;

   // block row finished: partial sum on its way to the line store or divider
   typedef struct packed {
      logic             first_row;
      logic             last_row;
      logic             frame_end;
      logic [POS_W-1:0] ox;
      logic [POS_W-1:0] oy;
      rgb_sum_type      sum;
   } blk_word_type;

   // one stage of the restoring divider
   typedef struct packed {
      logic             frame_end;
      logic [POS_W-1:0] ox;
      logic [POS_W-1:0] oy;
      rgb_sum_type      rem;
      rgb_quo_type      quo;
   } div_word_type;

   typedef struct packed {
      logic [SUM_W-1:0] rem;
      logic             hit;
   } div_step_type;

   function automatic div_step_type div_step(input logic [SUM_W-1:0] rem,
                                             input logic [SUM_W-1:0] dvs);
      div_step_type res;
      res.hit = (rem >= dvs);
      res.rem = res.hit ? rem - dvs : rem;
      return res;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/box_average_downscaler.sv =====
// box_average_downscaler: top level of the box filter image downscaler
// uses bxds_pkg for sum words, stage words and register indexes
// holds the column-sum line store, position counters and the divider pipeline
`default_nettype none

// Box average downscaler. Source RGB pixels enter in raster order on the req
// channel, one word per pixel. The image is cut into factor x factor blocks
// and for each whole block one rsp word carries the floor average of each
// channel, its column and row in the reduced image and a frame_end flag on
// the last block of the frame. Pixels in a right or bottom remainder that do
// not fill a block are dropped, and nothing comes out when the reduced width
// or height is zero. Rate: one pixel per clock while rsp_stall does not hold
// the output, with no pause at row or frame ends. The line store (synchronous
// memory with one read and one write port, one entry per reduced column) is
// read into a register at the accepting edge, then the add feeds the eight
// stage restoring divider that divides by factor squared, one register per
// stage. When a result waits under rsp_stall the whole pipeline holds, and
// req_stall follows. The line store needs no clearing pass after reset: an
// entry is always written by the first block row before the next block row
// reads it. A write to a named csr register restarts the frame; write it
// only while no block is in flight.

module box_average_downscaler
   import bxds_pkg::*;
#(
   parameter int MAX_OUT_WIDTH = 4096,
   parameter int MAX_FACTOR    = 16
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   // source pixel channel
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire logic [PIX_W-1:0]     req_red_in,
   input  wire logic [PIX_W-1:0]     req_green_in,
   input  wire logic [PIX_W-1:0]     req_blue_in,
   // reduced pixel channel
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output logic [PIX_W-1:0]          rsp_red_avg,
   output logic [PIX_W-1:0]          rsp_green_avg,
   output logic [PIX_W-1:0]          rsp_blue_avg,
   output logic [POS_W-1:0]          rsp_out_column,
   output logic [POS_W-1:0]          rsp_out_row,
   output logic                      rsp_frame_end,
   // register write port
   input  wire logic                 csr_write_enable,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [DIM_W-1:0]     csr_write_data
);

   localparam int AW         = $clog2(MAX_OUT_WIDTH);
   localparam int DIV_STAGES = QUO_W;

   // ---------------------------------------------------------------- config
   logic [DIM_W-1:0]  width_ff, height_ff;
   logic [FACT_W-1:0] factor_ff;
   logic              restart;

   // effective values after clamping
   logic [DIM_W-1:0]  w_eff, h_eff, count_w, count_h;
   logic [FACT_W-1:0] f_eff;
   logic [N_W-1:0]    n_eff;

   always_comb begin
      w_eff   = (width_ff  > DIM_MAX) ? DIM_MAX : width_ff;
      h_eff   = (height_ff > DIM_MAX) ? DIM_MAX : height_ff;
      count_w = (w_eff == '0) ? DIM_W'(1) : w_eff;
      count_h = (h_eff == '0) ? DIM_W'(1) : h_eff;
      if (factor_ff == '0) begin
         f_eff = FACT_W'(1);
      end else if (32'(factor_ff) > MAX_FACTOR) begin
         f_eff = FACT_W'(MAX_FACTOR);
      end else begin
         f_eff = factor_ff;
      end
      n_eff = N_W'(f_eff) * N_W'(f_eff);
   end

   // unknown indexes are dropped and do not restart the frame
   always_comb begin
      restart = 1'b0;
      if (csr_write_enable) begin
         unique case (csr_reg_type'(csr_index))
            CSR_SOURCE_WIDTH:  restart = 1'b1;
            CSR_SOURCE_HEIGHT: restart = 1'b1;
            CSR_SCALE_FACTOR:  restart = 1'b1;
            default:           restart = 1'b0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
         factor_ff <= FACTOR_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_reg_type'(csr_index))
            CSR_SOURCE_WIDTH:  width_ff  <= csr_write_data;
            CSR_SOURCE_HEIGHT: height_ff <= csr_write_data;
            CSR_SCALE_FACTOR:  factor_ff <= csr_write_data[FACT_W-1:0];
            default: ;
         endcase
      end
   end

   // --------------------------------------------------------------- control
   // the pipeline moves as one unless the output word is held
   logic en;
   logic req_accept;
   logic dv_ff [DIV_STAGES];

   assign en         = !(dv_ff[DIV_STAGES-1] && rsp_stall);
   assign req_stall  = !en;
   assign req_accept = req_valid && en;

   // ------------------------------------------------------ position counters
   // source column/row, offset inside the block, block start and block index
   logic [POS_W-1:0]  col_ff, col_in, row_ff, row_in;
   logic [FACT_W-1:0] dx_ff, dx_in, dy_ff, dy_in;
   logic [DIM_W-1:0]  bx_ff, bx_in, by_ff, by_in;
   logic [POS_W-1:0]  ox_ff, ox_in, oy_ff, oy_in;

   logic col_last, row_last, dx_last, dy_last;
   logic fits, last_ox, last_oy;

   always_comb begin
      col_last = (14'(col_ff) + 14'd1) >= 14'(count_w);
      row_last = (14'(row_ff) + 14'd1) >= 14'(count_h);
      dx_last  = (dx_ff == f_eff - FACT_W'(1));
      dy_last  = (dy_ff == f_eff - FACT_W'(1));
      // block lies inside the source image and inside the line store
      fits     = ((14'(bx_ff) + 14'(f_eff)) <= 14'(w_eff))
              && ((14'(by_ff) + 14'(f_eff)) <= 14'(h_eff))
              && (32'(ox_ff) < MAX_OUT_WIDTH);
      // no room for another whole block to the right or below
      last_ox  = (15'(bx_ff) + 15'({f_eff, 1'b0})) > 15'(w_eff);
      last_oy  = (15'(by_ff) + 15'({f_eff, 1'b0})) > 15'(h_eff);
   end

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      dx_in  = dx_ff;
      dy_in  = dy_ff;
      bx_in  = bx_ff;
      by_in  = by_ff;
      ox_in  = ox_ff;
      oy_in  = oy_ff;
      if (col_last) begin
         col_in = '0;
         dx_in  = '0;
         bx_in  = '0;
         ox_in  = '0;
         if (row_last) begin
            row_in = '0;
            dy_in  = '0;
            by_in  = '0;
            oy_in  = '0;
         end else begin
            row_in = row_ff + POS_W'(1);
            if (dy_last) begin
               dy_in = '0;
               by_in = by_ff + DIM_W'(f_eff);
               oy_in = oy_ff + POS_W'(1);
            end else begin
               dy_in = dy_ff + FACT_W'(1);
            end
         end
      end else begin
         col_in = col_ff + POS_W'(1);
         if (dx_last) begin
            dx_in = '0;
            bx_in = bx_ff + DIM_W'(f_eff);
            ox_in = ox_ff + POS_W'(1);
         end else begin
            dx_in = dx_ff + FACT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset || restart) begin
         col_ff <= '0;
         row_ff <= '0;
         dx_ff  <= '0;
         dy_ff  <= '0;
         bx_ff  <= '0;
         by_ff  <= '0;
         ox_ff  <= '0;
         oy_ff  <= '0;
      end else if (req_accept) begin
         col_ff <= col_in;
         row_ff <= row_in;
         dx_ff  <= dx_in;
         dy_ff  <= dy_in;
         bx_ff  <= bx_in;
         by_ff  <= by_in;
         ox_ff  <= ox_in;
         oy_ff  <= oy_in;
      end
   end

   // ----------------------------------------------------- row sum of a block
   rgb_sum_type pend_ff, pend_in;
   logic        blk_done;

   always_comb begin
      if (dx_ff == '0) begin
         pend_in.r = SUM_W'(req_red_in);
         pend_in.g = SUM_W'(req_green_in);
         pend_in.b = SUM_W'(req_blue_in);
      end else begin
         pend_in.r = pend_ff.r + SUM_W'(req_red_in);
         pend_in.g = pend_ff.g + SUM_W'(req_green_in);
         pend_in.b = pend_ff.b + SUM_W'(req_blue_in);
      end
   end

   assign blk_done = req_accept && fits && dx_last;

   always_ff @(posedge clock) begin
      if (reset || restart) begin
         pend_ff <= '0;
      end else if (req_accept && fits) begin
         pend_ff <= pend_in;
      end
   end

   // --------------------------------------------- line store and row merge
   logic [3*SUM_W-1:0] line_mem [MAX_OUT_WIDTH];
   logic [3*SUM_W-1:0] rd_ff;
   logic               b_valid_ff;
   blk_word_type       b_ff, b_in;
   rgb_sum_type        b_prev, b_total;
   logic               mem_write;

   always_comb begin
      b_in.first_row = (dy_ff == '0);
      b_in.last_row  = dy_last;
      b_in.frame_end = last_ox && last_oy;
      b_in.ox        = ox_ff;
      b_in.oy        = oy_ff;
      b_in.sum       = pend_in;
   end

   // earlier block rows of this column add in, the first row starts fresh
   always_comb begin
      b_prev    = rgb_sum_type'(rd_ff);
      b_total.r = b_ff.sum.r + (b_ff.first_row ? '0 : b_prev.r);
      b_total.g = b_ff.sum.g + (b_ff.first_row ? '0 : b_prev.g);
      b_total.b = b_ff.sum.b + (b_ff.first_row ? '0 : b_prev.b);
   end

   assign mem_write = en && b_valid_ff && !b_ff.last_row;

   // a column is rewritten a whole source row before it is read again,
   // so the read at accept never overlaps the write-back
   always_ff @(posedge clock) begin
      if (mem_write) begin
         line_mem[AW'(b_ff.ox)] <= b_total;
      end
      if (blk_done) begin
         rd_ff <= line_mem[AW'(ox_ff)];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (en) begin
         b_valid_ff <= blk_done;
      end
   end

   always_ff @(posedge clock) begin
      if (blk_done) begin
         b_ff <= b_in;
      end
   end

   // ------------------------------------------ divide by factor squared
   // restoring divider, one quotient bit per stage, msb first; the average
   // never exceeds 255 so eight bits are enough
   div_word_type d_ff [DIV_STAGES];
   div_word_type d_in [DIV_STAGES];
   logic         dv_in [DIV_STAGES];

   always_comb begin
      div_word_type     src;
      logic             src_v;
      logic [SUM_W-1:0] dvs;
      div_step_type     sr, sg, sb;
      for (int s = 0; s < DIV_STAGES; s++) begin
         if (s == 0) begin
            src_v         = b_valid_ff && b_ff.last_row;
            src.frame_end = b_ff.frame_end;
            src.ox        = b_ff.ox;
            src.oy        = b_ff.oy;
            src.rem       = b_total;
            src.quo       = '0;
         end else begin
            src_v = dv_ff[s-1];
            src   = d_ff[s-1];
         end
         dvs          = SUM_W'(n_eff) << (QUO_W - 1 - s);
         sr           = div_step(src.rem.r, dvs);
         sg           = div_step(src.rem.g, dvs);
         sb           = div_step(src.rem.b, dvs);
         d_in[s]      = src;
         d_in[s].rem.r = sr.rem;
         d_in[s].rem.g = sg.rem;
         d_in[s].rem.b = sb.rem;
         d_in[s].quo.r[QUO_W-1-s] = sr.hit;
         d_in[s].quo.g[QUO_W-1-s] = sg.hit;
         d_in[s].quo.b[QUO_W-1-s] = sb.hit;
         dv_in[s]     = src_v;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < DIV_STAGES; s++) begin
            dv_ff[s] <= 1'b0;
         end
      end else if (en) begin
         for (int s = 0; s < DIV_STAGES; s++) begin
            dv_ff[s] <= dv_in[s];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int s = 0; s < DIV_STAGES; s++) begin
            d_ff[s] <= d_in[s];
         end
      end
   end

   // ------------------------------------------------------------ output word
   assign rsp_valid      = dv_ff[DIV_STAGES-1];
   assign rsp_red_avg    = d_ff[DIV_STAGES-1].quo.r;
   assign rsp_green_avg  = d_ff[DIV_STAGES-1].quo.g;
   assign rsp_blue_avg   = d_ff[DIV_STAGES-1].quo.b;
   assign rsp_out_column = d_ff[DIV_STAGES-1].ox;
   assign rsp_out_row    = d_ff[DIV_STAGES-1].oy;
   assign rsp_frame_end  = d_ff[DIV_STAGES-1].frame_end;

   // ------------------------------------------------------------- assertions
   // block start plus offset tracks the source position
   a_col_track: assert property (@(posedge clock) disable iff (reset)
      (14'(bx_ff) + 14'(dx_ff)) == 14'(col_ff))
      else $error("column block start and offset disagree with column");

   a_row_track: assert property (@(posedge clock) disable iff (reset)
      (14'(by_ff) + 14'(dy_ff)) == 14'(row_ff))
      else $error("row block start and offset disagree with row");

   // the offset inside a block stays below the factor
   a_dx_range: assert property (@(posedge clock) disable iff (reset)
      dx_ff < f_eff && dy_ff < f_eff)
      else $error("block offset reached the factor");

   // a block that is first and last row at once only exists at factor one
   a_single_row: assert property (@(posedge clock) disable iff (reset)
      b_valid_ff && b_ff.first_row && b_ff.last_row |-> f_eff == FACT_W'(1))
      else $error("single row block at factor above one");

   // a held output word freezes the divider behind it
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(d_ff[DIV_STAGES-1].rem))
      else $error("output stage moved while stalled");

endmodule

`default_nettype wire

// ===== tb/tb_box_average_downscaler.sv =====
// tb_box_average_downscaler: self-checking testbench for the box average downscaler
// drives source pixels and register writes, checks reduced pixels against a block-sum tracker
// depends on bxds_pkg and box_average_downscaler
`default_nettype none

module tb_box_average_downscaler
   import bxds_pkg::*;
();

   // must match the parameters of the instance below
   localparam int unsigned FACTOR_CAP = 16;
   localparam int unsigned LINE_COLS  = 4096;
   // the one index the csr port can carry that names no register
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 2'd3;
   // the drain outlasts the line store register and the divider stages, so it covers any block in flight
   localparam int DRAIN_CYCLES  = 20;
   localparam int RANDOM_PIXELS = 1050;
   localparam int CYCLE_LIMIT   = 600000;

   typedef struct {
      int unsigned r;
      int unsigned g;
      int unsigned b;
   } chan_sum_type;

   typedef struct packed {
      logic [PIX_W-1:0] red;
      logic [PIX_W-1:0] green;
      logic [PIX_W-1:0] blue;
      logic [POS_W-1:0] column;
      logic [POS_W-1:0] row;
      logic             last;
   } reduced_pixel_type;

   // tracks source position and per-column block sums, and queues the block
   // averages that the accepted pixels must bring out
   class block_avg_tracker_type;
      logic [DIM_W-1:0]  width_reg  = WIDTH_RESET;
      logic [DIM_W-1:0]  height_reg = HEIGHT_RESET;
      logic [FACT_W-1:0] factor_reg = FACTOR_RESET;
      chan_sum_type      col_sum [LINE_COLS];
      chan_sum_type      run_sum;
      int unsigned       src_col;
      int unsigned       src_row;
      reduced_pixel_type due_pixels [$];
      int unsigned       mismatches;

      function void write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [DIM_W-1:0] data);
         case (idx)
            CSR_SOURCE_WIDTH:  width_reg = data;
            CSR_SOURCE_HEIGHT: height_reg = data;
            CSR_SCALE_FACTOR:  factor_reg = data[FACT_W-1:0];
            default: return;
         endcase
         src_col = 0;
         src_row = 0;
         run_sum = '{0, 0, 0};
      endfunction

      function void note_pixel(input logic [PIX_W-1:0] red, green, blue);
         int unsigned w, h, f, out_w, out_h, cnt_w, cnt_h, ox, oy, dx, dy, n;
         chan_sum_type tot;
         reduced_pixel_type px;
         w = (width_reg > DIM_MAX) ? DIM_MAX : width_reg;
         h = (height_reg > DIM_MAX) ? DIM_MAX : height_reg;
         f = (factor_reg == 0) ? 1 : ((factor_reg > FACTOR_CAP) ? FACTOR_CAP : factor_reg);
         out_w = w / f;
         out_h = h / f;
         cnt_w = (w == 0) ? 1 : w;
         cnt_h = (h == 0) ? 1 : h;
         ox = src_col / f;
         dx = src_col % f;
         oy = src_row / f;
         dy = src_row % f;
         if (ox < out_w && oy < out_h && ox < LINE_COLS) begin
            if (dx == 0) begin
               run_sum = '{red, green, blue};
            end else begin
               run_sum.r += red;
               run_sum.g += green;
               run_sum.b += blue;
            end
            if (dx == f - 1) begin
               tot = run_sum;
               if (dy != 0) begin
                  tot.r += col_sum[ox].r;
                  tot.g += col_sum[ox].g;
                  tot.b += col_sum[ox].b;
               end
               if (dy == f - 1) begin
                  n = f * f;
                  px.red    = PIX_W'(tot.r / n);
                  px.green  = PIX_W'(tot.g / n);
                  px.blue   = PIX_W'(tot.b / n);
                  px.column = POS_W'(ox);
                  px.row    = POS_W'(oy);
                  px.last   = (ox == out_w - 1 && oy == out_h - 1);
                  due_pixels = {due_pixels, px};
               end else begin
                  col_sum[ox] = tot;
               end
            end
         end
         if (src_col + 1 >= cnt_w) begin
            src_col = 0;
            src_row = (src_row + 1 >= cnt_h) ? 0 : src_row + 1;
         end else begin
            src_col = src_col + 1;
         end
      endfunction

      function void check_pixel(input logic [PIX_W-1:0] red, green, blue,
                                input logic [POS_W-1:0] column, row, input logic last);
         reduced_pixel_type want;
         if (due_pixels.size() == 0) begin
            $error("reduced pixel with none due: column %0d row %0d", column, row);
            mismatches++;
            return;
         end
         want = due_pixels.pop_front();
         if (red !== want.red) begin
            $error("red_avg: expected %0d, got %0d", want.red, red);
            mismatches++;
         end
         if (green !== want.green) begin
            $error("green_avg: expected %0d, got %0d", want.green, green);
            mismatches++;
         end
         if (blue !== want.blue) begin
            $error("blue_avg: expected %0d, got %0d", want.blue, blue);
            mismatches++;
         end
         if (column !== want.column) begin
            $error("out_column: expected %0d, got %0d", want.column, column);
            mismatches++;
         end
         if (row !== want.row) begin
            $error("out_row: expected %0d, got %0d", want.row, row);
            mismatches++;
         end
         if (last !== want.last) begin
            $error("frame_end: expected %0d, got %0d", want.last, last);
            mismatches++;
         end
      endfunction

      function int unsigned due_count();
         return due_pixels.size();
      endfunction
   endclass

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid;
   logic                 req_stall;
   logic [PIX_W-1:0]     req_red_in;
   logic [PIX_W-1:0]     req_green_in;
   logic [PIX_W-1:0]     req_blue_in;
   logic                 rsp_valid;
   logic                 rsp_stall;
   logic [PIX_W-1:0]     rsp_red_avg;
   logic [PIX_W-1:0]     rsp_green_avg;
   logic [PIX_W-1:0]     rsp_blue_avg;
   logic [POS_W-1:0]     rsp_out_column;
   logic [POS_W-1:0]     rsp_out_row;
   logic                 rsp_frame_end;
   logic                 csr_write_enable;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [DIM_W-1:0]     csr_write_data;

   block_avg_tracker_type board;
   // no idling on either side while set, so back-to-back words get through too
   bit                   calm;
   int unsigned          pixels_sent;
   int unsigned          cycle_count;

   box_average_downscaler dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_red_in       (req_red_in),
      .req_green_in     (req_green_in),
      .req_blue_in      (req_blue_in),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_red_avg      (rsp_red_avg),
      .rsp_green_avg    (rsp_green_avg),
      .rsp_blue_avg     (rsp_blue_avg),
      .rsp_out_column   (rsp_out_column),
      .rsp_out_row      (rsp_out_row),
      .rsp_frame_end    (rsp_frame_end),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // hard stop in case a handshake never completes
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // both channels are watched at the rising edge: a word moves when valid is
   // high and stall is low, pixels go into the tracker, results are checked
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall)
            board.note_pixel(req_red_in, req_green_in, req_blue_in);
         if (rsp_valid && !rsp_stall)
            board.check_pixel(rsp_red_avg, rsp_green_avg, rsp_blue_avg,
                              rsp_out_column, rsp_out_row, rsp_frame_end);
      end
   end

   // result side: before each word, stall for a random hold, none while calm, then take it
   initial begin : receiver
      int hold;
      rsp_stall = 1'b0;
      wait (!reset);
      forever begin
         hold = calm ? 0 : $urandom_range(0, 3);
         repeat (hold) begin
            @(negedge clock);
            rsp_stall <= 1'b1;
         end
         @(negedge clock);
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   // one source pixel word; valid drops only for the drawn gap, and the
   // payload holds until the block takes it
   task automatic send_pixel(input logic [PIX_W-1:0] red, green, blue);
      int gap;
      gap = calm ? 0 : $urandom_range(0, 3);
      repeat (gap) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid    <= 1'b1;
      req_red_in   <= red;
      req_green_in <= green;
      req_blue_in  <= blue;
      do @(posedge clock); while (req_stall);
      pixels_sent++;
   endtask

   task automatic send_random_pixels(input int unsigned count);
      repeat (count)
         send_pixel(PIX_W'($urandom_range(0, 255)), PIX_W'($urandom_range(0, 255)),
                    PIX_W'($urandom_range(0, 255)));
   endtask

   // register write, one cycle of enable; the tracker sees it at the same edge
   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [DIM_W-1:0] data);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      @(posedge clock);
      board.write_reg(idx, data);
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic write_frame(input int unsigned w, h, f);
      write_csr(CSR_SOURCE_WIDTH, DIM_W'(w));
      write_csr(CSR_SOURCE_HEIGHT, DIM_W'(h));
      write_csr(CSR_SCALE_FACTOR, DIM_W'(f));
   endtask

   // wait out every due result, then the pipeline, so the block is idle;
   // pixels that feed only the line store give no result to wait on
   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (board.due_count() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   initial begin : stimulus
      int unsigned f, ef, w, h, cw, ch, frame, count, pick, random_start;
      board            = new;
      req_valid        = 1'b0;
      req_red_in       = '0;
      req_green_in     = '0;
      req_blue_in      = '0;
      csr_write_enable = 1'b0;
      csr_index        = CSR_SOURCE_WIDTH;
      csr_write_data   = '0;
      calm             = 1'b0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset settings, 640 x 480 by 2: a partial frame, cut off by the writes below
      send_pixel(8'd255, 8'd255, 8'd255);
      send_pixel(8'd0, 8'd0, 8'd0);
      settle();

      // a single 2 x 2 block: floor average, frame end, then wrap
      write_frame(2, 2, 2);
      send_pixel(8'd255, 8'd0, 8'd255);
      send_pixel(8'd255, 8'd0, 8'd255);
      send_pixel(8'd255, 8'd0, 8'd254);
      send_pixel(8'd255, 8'd255, 8'd255);
      settle();

      // width over the top saturates, factor zero acts as one
      write_frame(8191, 1, 0);
      send_pixel(8'd128, 8'd1, 8'd254);
      send_pixel(8'd127, 8'd2, 8'd253);
      send_pixel(8'd0, 8'd255, 8'd0);
      settle();

      // factor over the cap saturates, and the reduced image is empty
      write_frame(3, 2, 31);
      send_random_pixels(3);
      settle();

      // zero width, then zero height: nothing comes out
      write_frame(0, 4, 1);
      send_random_pixels(2);
      settle();
      write_frame(4, 0, 1);
      send_random_pixels(2);
      settle();

      // one pixel frames; a write to the spare index changes nothing
      write_frame(1, 1, 1);
      send_random_pixels(1);
      settle();
      write_csr(CSR_SPARE, DIM_W'($urandom_range(0, 8191)));
      send_random_pixels(1);

      // random phases: mostly whole frames with random content, some cut
      // short, some with odd dimensions
      random_start = pixels_sent;
      while (pixels_sent - random_start < RANDOM_PIXELS) begin
         pick = $urandom_range(0, 9);
         if (pick < 6)
            f = $urandom_range(1, 4);
         else if (pick < 9)
            f = $urandom_range(5, FACTOR_CAP);
         else if ($urandom_range(0, 1) != 0)
            f = 0;
         else
            f = $urandom_range(FACTOR_CAP + 1, 31);
         ef = (f == 0) ? 1 : ((f > FACTOR_CAP) ? FACTOR_CAP : f);
         w = ef * $urandom_range(1, 4) + $urandom_range(0, ef - 1);
         h = ef * $urandom_range(1, 3) + $urandom_range(0, ef - 1);
         pick = $urandom_range(0, 19);
         if (pick == 0)
            w = 0;
         else if (pick == 1)
            h = 0;
         else if (pick == 2)
            w = $urandom_range(4097, 8191);
         else if (pick == 3) begin
            w = 4096;
            h = ef;
         end
         cw = (w == 0) ? 1 : ((w > 4096) ? 4096 : w);
         ch = (h == 0) ? 1 : ((h > 4096) ? 4096 : h);
         frame = cw * ch;
         if (frame <= 300)
            count = frame * $urandom_range(1, 3);
         else if (frame <= 1500)
            count = frame;
         else
            count = $urandom_range(20, 300);
         // broken tail: the next write restarts the frame partway through
         if ($urandom_range(0, 3) == 0)
            count += $urandom_range(1, 100);
         // keep the random phase near its pixel budget
         if (count > RANDOM_PIXELS - (pixels_sent - random_start))
            count = RANDOM_PIXELS - (pixels_sent - random_start);

         settle();
         calm = ($urandom_range(0, 4) == 0);
         if ($urandom_range(0, 7) == 0)
            write_csr(CSR_SPARE, DIM_W'($urandom_range(0, 8191)));
         write_frame(w, h, f);
         send_random_pixels(count);
      end

      settle();
      if (board.mismatches == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule

`default_nettype wire
